>>> hdl/gbht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbht_pkg
// Shared types, codes and constants of the grid bilinear height table.
// ----------------------------------------------------------------------------
package gbht_pkg;

  localparam int DEF_MAX_POINTS      = 256;
  localparam int DEF_MAX_AXIS_VALUES = 32;

  localparam int COORD_W  = 16;
  localparam int HEIGHT_W = 24;

  // Operand widths of the multiply-divide unit.
  localparam int MD_A_W = 48;
  localparam int MD_B_W = 17;
  localparam int MD_P_W = 64;

  localparam logic signed [MD_P_W-1:0] H_MAX = 64'sd8388607;
  localparam logic signed [MD_P_W-1:0] H_MIN = -64'sd8388608;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;
  localparam logic [1:0] ACT_RANGE = 2'd3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_H = 2'd2;
  localparam logic [1:0] AXIS_BAD = 2'd3;

  typedef struct packed {
    logic [1:0]                 action;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [HEIGHT_W-1:0] height_in;
    logic [1:0]                 range_axis;
  } in_word_t;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] height_out;
    logic signed [HEIGHT_W-1:0] range_low;
    logic signed [HEIGHT_W-1:0] range_high;
    logic                       corner_missing;
    logic                       table_full;
    logic                       saturated;
  } out_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [HEIGHT_W-1:0] h;
  } point_t;

  localparam int POINT_W = $bits(point_t);

endpackage

>>> hdl/gbht_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbht_item_if
// Valid/ready channel that carries one command word.
// ----------------------------------------------------------------------------
interface gbht_item_if;
  logic               valid;
  logic               ready;
  gbht_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/gbht_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbht_result_if
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface gbht_result_if;
  logic                valid;
  logic                ready;
  gbht_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/grid_bilinear_height_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_bilinear_height_table
// Point table with sorted axis lists and bilinear height lookup.
// ----------------------------------------------------------------------------
// One command word in, one result word out. The block works on one command
// at a time; item.ready is high while the sequencer is idle, and a finished
// result waits in an output register so the next command can be taken.
// Clear only resets the counts; range walks the point RAM once; add walks
// the point RAM, then both axis lists, then, if the table has room, moves
// list entries up one slot for each new axis value; a duplicate add ends at
// the match. A query on a single point walks the point RAM only; a height
// query walks both axis lists, reads the cell bounds, walks the point RAM
// for the corners, then makes up to three passes of the serial
// multiply-divide unit (17 multiply steps and 64 divide steps each). The
// point RAM read port, walked at most once per command, and the
// multiply-divide unit set how long a command takes; a held result word
// adds its wait.
// No clearing pass is needed after reset: the counts alone mark valid data.
module grid_bilinear_height_table #(
  parameter int MAX_POINTS      = gbht_pkg::DEF_MAX_POINTS,
  parameter int MAX_AXIS_VALUES = gbht_pkg::DEF_MAX_AXIS_VALUES
) (
  input logic                clk,
  input logic                rst,
  gbht_item_if.sink          item,
  gbht_result_if.source      result
);

  localparam int PT_AW = $clog2(MAX_POINTS);
  localparam int PT_CW = $clog2(MAX_POINTS + 1);
  localparam int AX_AW = $clog2(MAX_AXIS_VALUES);
  localparam int AX_CW = $clog2(MAX_AXIS_VALUES + 1);
  localparam int CW    = gbht_pkg::COORD_W;
  localparam int HW    = gbht_pkg::HEIGHT_W;
  localparam int AW    = gbht_pkg::MD_A_W;
  localparam int BW    = gbht_pkg::MD_B_W;
  localparam int PW    = gbht_pkg::MD_P_W;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_PSCAN  = 10'b00_0000_0010,
    S_ASCAN  = 10'b00_0000_0100,
    S_AFETCH = 10'b00_0000_1000,
    S_CHECK  = 10'b00_0001_0000,
    S_SHRD   = 10'b00_0010_0000,
    S_SHWR   = 10'b00_0100_0000,
    S_MD     = 10'b00_1000_0000,
    S_SAT    = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_t;

  state_t              state;
  gbht_pkg::in_word_t  cmd;
  gbht_pkg::out_word_t stage_out;
  gbht_pkg::out_word_t res_data;
  logic                res_valid;

  // Counts: the only table state that reset must touch.
  logic [PT_CW-1:0] point_count;
  logic [AX_CW-1:0] x_count;
  logic [AX_CW-1:0] y_count;

  // Point scan
  logic [PT_CW-1:0] scan_idx;
  logic             scan_pend;
  logic [PT_AW-1:0] pend_idx;

  // Axis scan
  logic [AX_CW-1:0] ax_idx;
  logic             pend_x, pend_y;
  logic [AX_CW-1:0] le_x, lt_x, le_y, lt_y;
  logic             eq_x, eq_y;

  // Cell bounds and corners
  logic [1:0]               fetch_step;
  logic signed [CW-1:0]     xl_v, xu_v, yl_v, yu_v;
  logic signed [HW-1:0]     c_ll, c_lu, c_ul, c_uu;
  logic [3:0]               found;
  logic signed [HW-1:0]     first_h, rng_lo, rng_hi;

  // List insertion
  logic [AX_CW-1:0] sh_idx, sh_pos;
  logic             sh_sel_y;

  // Interpolation
  logic [1:0]           md_stage;
  logic                 md_run;
  logic signed [PW-1:0] hx1, hx2, h_acc;

  // RAM ports
  logic                           pt_we;
  logic [PT_AW-1:0]               pt_waddr, pt_raddr;
  logic [gbht_pkg::POINT_W-1:0]   pt_wdata, pt_rdata;
  gbht_pkg::point_t               pt_rd;
  logic                           x_we, y_we;
  logic [AX_AW-1:0]               x_waddr, x_raddr, y_waddr, y_raddr;
  logic [CW-1:0]                  x_wdata, y_wdata, x_rdata, y_rdata;
  logic signed [CW-1:0]           x_rd, y_rd;

  // Combinational control
  logic             pt_issue, ax_issue_x, ax_issue_y;
  logic             match_xy, add_full;
  logic [AX_CW-1:0] x_lo, x_hi, y_lo, y_hi, sh_prev;
  logic signed [BW-1:0] dx, dy, span_x, span_y;
  logic                 md_start, md_done;
  logic signed [AW-1:0] md_a;
  logic signed [BW-1:0] md_b;
  logic [BW-1:0]        md_d;
  logic signed [PW-1:0] md_q;
  logic signed [HW-1:0] range_v;

  assign pt_rd = gbht_pkg::point_t'(pt_rdata);
  assign x_rd  = $signed(x_rdata);
  assign y_rd  = $signed(y_rdata);

  assign pt_issue   = (state == S_PSCAN) && (scan_idx < point_count);
  assign ax_issue_x = (state == S_ASCAN) && (ax_idx < x_count);
  assign ax_issue_y = (state == S_ASCAN) && (ax_idx < y_count);
  assign match_xy   = (pt_rd.x == cmd.coord_x) && (pt_rd.y == cmd.coord_y);

  assign add_full = (point_count == PT_CW'(MAX_POINTS)) ||
                    (!eq_x && (x_count == AX_CW'(MAX_AXIS_VALUES))) ||
                    (!eq_y && (y_count == AX_CW'(MAX_AXIS_VALUES)));

  // Cell index from the count of list entries at or below the coordinate;
  // clamp to the first or last cell for extrapolation.
  always_comb begin
    if (x_count <= AX_CW'(1))       x_lo = '0;
    else if (le_x == '0)            x_lo = '0;
    else if (le_x >= x_count)       x_lo = x_count - AX_CW'(2);
    else                            x_lo = le_x - AX_CW'(1);
    x_hi = (x_count <= AX_CW'(1)) ? x_lo : x_lo + AX_CW'(1);
    if (y_count <= AX_CW'(1))       y_lo = '0;
    else if (le_y == '0)            y_lo = '0;
    else if (le_y >= y_count)       y_lo = y_count - AX_CW'(2);
    else                            y_lo = le_y - AX_CW'(1);
    y_hi = (y_count <= AX_CW'(1)) ? y_lo : y_lo + AX_CW'(1);
  end

  assign sh_prev = sh_idx - AX_CW'(1);

  // Point RAM: replace in place on a duplicate, append on a new point.
  assign pt_raddr = scan_idx[PT_AW-1:0];
  assign pt_we    = ((state == S_PSCAN) && (cmd.action == gbht_pkg::ACT_ADD) &&
                     scan_pend && match_xy) ||
                    ((state == S_CHECK) && !add_full);
  assign pt_waddr = (state == S_PSCAN) ? pend_idx : point_count[PT_AW-1:0];
  assign pt_wdata = {cmd.coord_x, cmd.coord_y, cmd.height_in};

  // Axis list RAMs
  always_comb begin
    x_raddr = ax_idx[AX_AW-1:0];
    y_raddr = ax_idx[AX_AW-1:0];
    if (state == S_AFETCH) begin
      x_raddr = (fetch_step == 2'd0) ? x_lo[AX_AW-1:0] : x_hi[AX_AW-1:0];
      y_raddr = (fetch_step == 2'd0) ? y_lo[AX_AW-1:0] : y_hi[AX_AW-1:0];
    end else if (state == S_SHRD) begin
      x_raddr = sh_prev[AX_AW-1:0];
      y_raddr = sh_prev[AX_AW-1:0];
    end
    x_we    = 1'b0;
    y_we    = 1'b0;
    x_waddr = sh_idx[AX_AW-1:0];
    y_waddr = sh_idx[AX_AW-1:0];
    x_wdata = x_rdata;
    y_wdata = y_rdata;
    if (state == S_SHWR) begin
      x_we = !sh_sel_y;
      y_we = sh_sel_y;
    end else if ((state == S_SHRD) && !(sh_idx > sh_pos)) begin
      // drop the new value into the gap
      x_we    = !sh_sel_y;
      y_we    = sh_sel_y;
      x_waddr = sh_pos[AX_AW-1:0];
      y_waddr = sh_pos[AX_AW-1:0];
      x_wdata = cmd.coord_x;
      y_wdata = cmd.coord_y;
    end
  end

  // Multiply-divide operands
  assign dx     = {cmd.coord_x[CW-1], cmd.coord_x} - {xl_v[CW-1], xl_v};
  assign dy     = {cmd.coord_y[CW-1], cmd.coord_y} - {yl_v[CW-1], yl_v};
  assign span_x = {xu_v[CW-1], xu_v} - {xl_v[CW-1], xl_v};
  assign span_y = {yu_v[CW-1], yu_v} - {yl_v[CW-1], yl_v};

  always_comb begin
    case (md_stage)
      2'd0:    md_a = AW'(c_lu) - AW'(c_ll);
      2'd1:    md_a = AW'(c_uu) - AW'(c_ul);
      default: md_a = AW'(hx2 - hx1);
    endcase
    md_b = (md_stage == 2'd2) ? dx : dy;
    md_d = (md_stage == 2'd2) ? span_x : span_y;
  end

  assign md_start = (state == S_MD) && !md_run;

  always_comb begin
    case (cmd.range_axis)
      gbht_pkg::AXIS_X: range_v = HW'(pt_rd.x);
      gbht_pkg::AXIS_Y: range_v = HW'(pt_rd.y);
      default:          range_v = pt_rd.h;
    endcase
  end

  assign item.ready   = (state == S_IDLE);
  assign result.valid = res_valid;
  assign result.data  = res_data;

  gbht_ram #(.WIDTH(gbht_pkg::POINT_W), .DEPTH(MAX_POINTS)) u_point_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  gbht_ram #(.WIDTH(CW), .DEPTH(MAX_AXIS_VALUES)) u_x_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (x_waddr),
    .wdata (x_wdata),
    .raddr (x_raddr),
    .rdata (x_rdata)
  );

  gbht_ram #(.WIDTH(CW), .DEPTH(MAX_AXIS_VALUES)) u_y_ram (
    .clk   (clk),
    .we    (y_we),
    .waddr (y_waddr),
    .wdata (y_wdata),
    .raddr (y_raddr),
    .rdata (y_rdata)
  );

  gbht_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .a     (md_a),
    .b     (md_b),
    .d     (md_d),
    .done  (md_done),
    .q     (md_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      res_valid   <= 1'b0;
      point_count <= '0;
      x_count     <= '0;
      y_count     <= '0;
      scan_pend   <= 1'b0;
      pend_x      <= 1'b0;
      pend_y      <= 1'b0;
      md_run      <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (result.valid && result.ready && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            cmd       <= item.data;
            stage_out <= '0;
            scan_idx  <= '0;
            scan_pend <= 1'b0;
            ax_idx    <= '0;
            pend_x    <= 1'b0;
            pend_y    <= 1'b0;
            le_x      <= '0;
            lt_x      <= '0;
            le_y      <= '0;
            lt_y      <= '0;
            eq_x      <= 1'b0;
            eq_y      <= 1'b0;
            case (item.data.action)
              gbht_pkg::ACT_ADD: state <= S_PSCAN;
              gbht_pkg::ACT_CLEAR: begin
                point_count <= '0;
                x_count     <= '0;
                y_count     <= '0;
                state       <= S_DONE;
              end
              gbht_pkg::ACT_QUERY: begin
                if (point_count == '0)            state <= S_DONE;
                else if (point_count == PT_CW'(1)) state <= S_PSCAN;
                else                              state <= S_ASCAN;
              end
              default: begin
                if (item.data.range_axis == gbht_pkg::AXIS_BAD ||
                    point_count == '0) begin
                  state <= S_DONE;
                end else begin
                  state <= S_PSCAN;
                end
              end
            endcase
          end
        end

        // Walk the point RAM; compare each word in the cycle after its read.
        S_PSCAN: begin
          if (pt_issue) begin
            scan_idx  <= scan_idx + PT_CW'(1);
            scan_pend <= 1'b1;
            pend_idx  <= scan_idx[PT_AW-1:0];
          end else begin
            scan_pend <= 1'b0;
          end
          if (scan_pend) begin
            if (pend_idx == '0) begin
              first_h <= pt_rd.h;
            end
            case (cmd.action)
              gbht_pkg::ACT_ADD: begin
                if (match_xy) begin
                  state <= S_DONE;
                end
              end
              gbht_pkg::ACT_RANGE: begin
                if (pend_idx == '0) begin
                  rng_lo <= range_v;
                  rng_hi <= range_v;
                end else begin
                  if (range_v < rng_lo) rng_lo <= range_v;
                  if (range_v > rng_hi) rng_hi <= range_v;
                end
              end
              default: begin
                if (!found[0] && pt_rd.x == xl_v && pt_rd.y == yl_v) begin
                  c_ll <= pt_rd.h;
                  found[0] <= 1'b1;
                end
                if (!found[1] && pt_rd.x == xl_v && pt_rd.y == yu_v) begin
                  c_lu <= pt_rd.h;
                  found[1] <= 1'b1;
                end
                if (!found[2] && pt_rd.x == xu_v && pt_rd.y == yl_v) begin
                  c_ul <= pt_rd.h;
                  found[2] <= 1'b1;
                end
                if (!found[3] && pt_rd.x == xu_v && pt_rd.y == yu_v) begin
                  c_uu <= pt_rd.h;
                  found[3] <= 1'b1;
                end
              end
            endcase
          end
          if (!pt_issue && !scan_pend) begin
            case (cmd.action)
              gbht_pkg::ACT_ADD: state <= S_ASCAN;
              gbht_pkg::ACT_RANGE: begin
                stage_out.range_low  <= rng_lo;
                stage_out.range_high <= rng_hi;
                state                <= S_DONE;
              end
              default: begin
                if (point_count == PT_CW'(1)) begin
                  stage_out.height_out <= first_h;
                  state                <= S_DONE;
                end else if (y_count > AX_CW'(1)) begin
                  md_stage <= 2'd0;
                  state    <= S_MD;
                end else begin
                  // single row: no y interpolation
                  hx1 <= PW'(c_ll);
                  hx2 <= PW'(c_ul);
                  h_acc <= PW'(c_ll);
                  md_stage <= 2'd2;
                  state <= (x_count > AX_CW'(1)) ? S_MD : S_SAT;
                end
              end
            endcase
          end
        end

        // Walk both axis lists together: count entries below / at the
        // coordinate and note an exact hit.
        S_ASCAN: begin
          if (ax_issue_x || ax_issue_y) begin
            ax_idx <= ax_idx + AX_CW'(1);
          end
          pend_x <= ax_issue_x;
          pend_y <= ax_issue_y;
          if (pend_x) begin
            if (x_rd < cmd.coord_x)  lt_x <= lt_x + AX_CW'(1);
            if (x_rd <= cmd.coord_x) le_x <= le_x + AX_CW'(1);
            if (x_rd == cmd.coord_x) eq_x <= 1'b1;
          end
          if (pend_y) begin
            if (y_rd < cmd.coord_y)  lt_y <= lt_y + AX_CW'(1);
            if (y_rd <= cmd.coord_y) le_y <= le_y + AX_CW'(1);
            if (y_rd == cmd.coord_y) eq_y <= 1'b1;
          end
          if (!ax_issue_x && !ax_issue_y && !pend_x && !pend_y) begin
            fetch_step <= 2'd0;
            state <= (cmd.action == gbht_pkg::ACT_ADD) ? S_CHECK : S_AFETCH;
          end
        end

        // Read the lower bounds, then the upper bounds of the cell.
        S_AFETCH: begin
          fetch_step <= fetch_step + 2'd1;
          if (fetch_step == 2'd1) begin
            xl_v <= x_rd;
            yl_v <= y_rd;
          end else if (fetch_step == 2'd2) begin
            xu_v      <= x_rd;
            yu_v      <= y_rd;
            found     <= '0;
            c_ll      <= '0;
            c_lu      <= '0;
            c_ul      <= '0;
            c_uu      <= '0;
            scan_idx  <= '0;
            scan_pend <= 1'b0;
            state     <= S_PSCAN;
          end
        end

        S_CHECK: begin
          if (add_full) begin
            stage_out.table_full <= 1'b1;
            state                <= S_DONE;
          end else begin
            point_count <= point_count + PT_CW'(1);
            if (!eq_x) begin
              sh_sel_y <= 1'b0;
              sh_idx   <= x_count;
              sh_pos   <= lt_x;
              state    <= S_SHRD;
            end else if (!eq_y) begin
              sh_sel_y <= 1'b1;
              sh_idx   <= y_count;
              sh_pos   <= lt_y;
              state    <= S_SHRD;
            end else begin
              state <= S_DONE;
            end
          end
        end

        // Move entries up one slot from the top down to the insert point.
        S_SHRD: begin
          if (sh_idx > sh_pos) begin
            state <= S_SHWR;
          end else if (!sh_sel_y) begin
            x_count <= x_count + AX_CW'(1);
            if (!eq_y) begin
              sh_sel_y <= 1'b1;
              sh_idx   <= y_count;
              sh_pos   <= lt_y;
            end else begin
              state <= S_DONE;
            end
          end else begin
            y_count <= y_count + AX_CW'(1);
            state   <= S_DONE;
          end
        end

        S_SHWR: begin
          sh_idx <= sh_prev;
          state  <= S_SHRD;
        end

        S_MD: begin
          if (md_start) begin
            md_run <= 1'b1;
          end
          if (md_done) begin
            md_run <= 1'b0;
            case (md_stage)
              2'd0: begin
                hx1      <= PW'(c_ll) + md_q;
                md_stage <= 2'd1;
              end
              2'd1: begin
                hx2 <= PW'(c_ul) + md_q;
                if (x_count > AX_CW'(1)) begin
                  md_stage <= 2'd2;
                end else begin
                  h_acc <= hx1;
                  state <= S_SAT;
                end
              end
              default: begin
                h_acc <= hx1 + md_q;
                state <= S_SAT;
              end
            endcase
          end
        end

        // Clip to 24 bits and flag the clip.
        S_SAT: begin
          if (h_acc > gbht_pkg::H_MAX) begin
            stage_out.height_out <= HW'(gbht_pkg::H_MAX);
            stage_out.saturated  <= 1'b1;
          end else if (h_acc < gbht_pkg::H_MIN) begin
            stage_out.height_out <= HW'(gbht_pkg::H_MIN);
            stage_out.saturated  <= 1'b1;
          end else begin
            stage_out.height_out <= h_acc[HW-1:0];
          end
          stage_out.corner_missing <= ~&found;
          state <= S_DONE;
        end

        // Hold until the output register is free.
        S_DONE: begin
          if (!res_valid || result.ready) begin
            res_data  <= stage_out;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    point_count <= PT_CW'(MAX_POINTS) && x_count <= AX_CW'(MAX_AXIS_VALUES) &&
    y_count <= AX_CW'(MAX_AXIS_VALUES))
    else $error("count beyond store depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> state != S_IDLE)
    else $error("accepted word left sequencer idle");

  a_done_loads_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && (!res_valid || result.ready) |=> res_valid && state == S_IDLE)
    else $error("finished result not loaded");

  a_md_single: assert property (@(posedge clk) disable iff (rst)
    md_done |-> state == S_MD && md_run)
    else $error("multiply-divide result with no request");

endmodule

>>> hdl/gbht_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbht_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gbht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/gbht_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbht_muldiv
// Serial signed a*b/d with truncation toward zero; d is positive.
// ----------------------------------------------------------------------------
module gbht_muldiv (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [gbht_pkg::MD_A_W-1:0]    a,
  input  logic signed [gbht_pkg::MD_B_W-1:0]    b,
  input  logic        [gbht_pkg::MD_B_W-1:0]    d,
  output logic                                  done,
  output logic signed [gbht_pkg::MD_P_W-1:0]    q
);

  localparam int AW = gbht_pkg::MD_A_W;
  localparam int BW = gbht_pkg::MD_B_W;
  localparam int PW = gbht_pkg::MD_P_W;
  localparam int CW = $clog2(PW);

  typedef enum logic [3:0] {
    MD_IDLE = 4'b0001,
    MD_MUL  = 4'b0010,
    MD_DIV  = 4'b0100,
    MD_FIN  = 4'b1000
  } md_state_t;

  md_state_t       state;
  logic [PW-1:0]   am;
  logic [BW-1:0]   bm;
  logic [PW-1:0]   p;
  logic [BW-1:0]   rem;
  logic [BW-1:0]   dv;
  logic [CW-1:0]   cnt;
  logic            neg;

  logic [AW-1:0]   a_abs;
  logic [BW-1:0]   b_abs;
  logic [BW:0]     trial;
  logic            ge;

  assign a_abs = a[AW-1] ? AW'(-a) : AW'(a);
  assign b_abs = b[BW-1] ? BW'(-b) : BW'(b);
  assign trial = {rem, p[PW-1]};
  assign ge    = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == MD_FIN);
      unique case (state)
        MD_IDLE: begin
          if (start) begin
            am    <= PW'(a_abs);
            bm    <= b_abs;
            p     <= '0;
            dv    <= d;
            neg   <= a[AW-1] ^ b[BW-1];
            cnt   <= '0;
            state <= MD_MUL;
          end
        end
        // shift-add: one multiplier bit per cycle
        MD_MUL: begin
          if (bm[0]) begin
            p <= p + am;
          end
          am  <= am << 1;
          bm  <= bm >> 1;
          if (cnt == CW'(BW - 1)) begin
            cnt   <= '0;
            rem   <= '0;
            state <= MD_DIV;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        // restoring division: one quotient bit per cycle
        MD_DIV: begin
          rem <= ge ? BW'(trial - {1'b0, dv}) : trial[BW-1:0];
          p   <= {p[PW-2:0], ge};
          cnt <= cnt + CW'(1);
          if (cnt == CW'(PW - 1)) begin
            state <= MD_FIN;
          end
        end
        MD_FIN: begin
          q     <= neg ? -$signed(p) : $signed(p);
          state <= MD_IDLE;
        end
        default: state <= MD_IDLE;
      endcase
    end
  end

endmodule
